// ===== rtl/core/cicd_pkg.sv =====
// Shared types and constants of the cloud-in-cell density deposit block.
package cicd_pkg;

	typedef enum logic [9:0] {
		S_CLR  = 10'b0000000001,
		S_IDLE = 10'b0000000010,
		S_MUL  = 10'b0000000100,
		S_CHK  = 10'b0000001000,
		S_M1   = 10'b0000010000,
		S_M2   = 10'b0000100000,
		S_M3   = 10'b0001000000,
		S_WR   = 10'b0010000000,
		S_RD   = 10'b0100000000,
		S_DONE = 10'b1000000000
	} state_t;

	localparam logic [1:0] ACT_CLEAR   = 2'd0;
	localparam logic [1:0] ACT_DEPOSIT = 2'd1;
	localparam logic [1:0] ACT_READ    = 2'd2;
	localparam logic [1:0] ACT_NOP     = 2'd3;

	localparam logic [2:0] REG_CELLS_X = 3'd0;
	localparam logic [2:0] REG_CELLS_Y = 3'd1;
	localparam logic [2:0] REG_CELLS_Z = 3'd2;
	localparam logic [2:0] REG_INV_X   = 3'd3;
	localparam logic [2:0] REG_INV_Y   = 3'd4;
	localparam logic [2:0] REG_INV_Z   = 3'd5;
	localparam logic [2:0] REG_WEIGHT  = 3'd6;

	localparam logic [16:0] W_ONE = 17'h10000;

endpackage

// ===== rtl/core/cloud_in_cell_density_deposit_top.sv =====
// Top level of the cloud-in-cell density deposit block.
// A deposit is scaled (S_MUL) and range checked (S_CHK), then each of the eight corners runs
// S_M1, S_M2, S_M3 and S_WR on the grid memory; S_DONE registers the result. Out of range goes to S_DONE.
// A read passes S_RD and S_DONE, an unused action only S_DONE; a clear sweeps one cell a cycle.
// The next transfer is taken in the cycle after a result is registered; an output stall holds it.
// After reset the same sweep runs and no transfer is taken until it ends.
module cloud_in_cell_density_deposit_top
	import cicd_pkg::*;
#(
	parameter int GRID_X = 16,
	parameter int GRID_Y = 16,
	parameter int GRID_Z = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [3:0]  read_x,
	input  logic [3:0]  read_y,
	input  logic [3:0]  read_z,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] density,
	output logic        out_of_range,
	output logic        saturated
);

	localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

	state_t state_q;
	logic [4:0]  cells_x_q, cells_y_q, cells_z_q;
	logic [31:0] inv_x_q, inv_y_q, inv_z_q, weight_q;

	logic [1:0]  act_q;
	logic [31:0] px_q, py_q, pz_q;
	logic [3:0]  rx_q, ry_q, rz_q;
	logic [47:0] sx_q, sy_q, sz_q;
	logic [8:0]  x0_q, x1_q, y0_q, y1_q, z0_q, z1_q;
	logic [15:0] fx_q, fy_q, fz_q;
	logic [2:0]  corner_q;
	logic [16:0] p1_q, p2_q;
	logic [32:0] w_q;
	logic [AW-1:0] addr_q;
	logic [AW:0]   clr_ptr_q;
	logic          resp_q;
	logic [31:0] res_dens_q;
	logic        res_oor_q, res_sat_q;
	logic        out_valid_q;
	logic [31:0] dens_q;
	logic        oor_q, sat_q;

	logic [8:0] nx, ny, nz;
	logic [31:0] ix, iy, iz;
	logic [16:0] wa, wb, wc;
	logic [8:0]  ca, cb, cc;
	logic [31:0] corner_addr, read_addr;
	logic        read_ok;
	logic        mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0] mem_wdata, mem_rdata;
	logic [33:0] sum;
	logic        sum_sat;
	logic [33:0] p1_full, p2_full;
	logic [48:0] w_full;
	logic        out_load;

	function automatic logic [8:0] eff_cells(input logic [4:0] v, input int grid);
		logic [8:0] g;
		g = 9'(grid);
		if (v < 5'd2) begin
			return 9'd2;
		end
		if ({4'd0, v} > g) begin
			return g;
		end
		return {4'd0, v};
	endfunction

	assign nx = eff_cells(cells_x_q, GRID_X);
	assign ny = eff_cells(cells_y_q, GRID_Y);
	assign nz = eff_cells(cells_z_q, GRID_Z);
	assign ix = sx_q[47:16];
	assign iy = sy_q[47:16];
	assign iz = sz_q[47:16];

	assign wa = corner_q[0] ? {1'b0, fx_q} : W_ONE - {1'b0, fx_q};
	assign wb = corner_q[1] ? {1'b0, fy_q} : W_ONE - {1'b0, fy_q};
	assign wc = corner_q[2] ? {1'b0, fz_q} : W_ONE - {1'b0, fz_q};
	assign ca = corner_q[0] ? x1_q : x0_q;
	assign cb = corner_q[1] ? y1_q : y0_q;
	assign cc = corner_q[2] ? z1_q : z0_q;

	assign p1_full = wa * wb;
	assign p2_full = p1_q * wc;
	assign w_full  = p2_q * weight_q;

	assign corner_addr = (32'(ca) * 32'(GRID_Y) + 32'(cb)) * 32'(GRID_Z) + 32'(cc);
	assign read_addr   = (32'(rx_q) * 32'(GRID_Y) + 32'(ry_q)) * 32'(GRID_Z) + 32'(rz_q);
	assign read_ok     = (32'(rx_q) < 32'(GRID_X)) && (32'(ry_q) < 32'(GRID_Y))
		&& (32'(rz_q) < 32'(GRID_Z));

	assign sum     = {2'b00, mem_rdata} + {1'b0, w_q};
	assign sum_sat = sum[33:32] != 2'b00;

	assign out_load = (state_q == S_DONE) && !(act_q == ACT_READ && read_ok && !resp_q)
		&& (!out_valid_q || !out_stall);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = sum_sat ? 32'hFFFF_FFFF : sum[31:0];
		mem_raddr = corner_addr[AW-1:0];
		case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_ptr_q[AW-1:0];
				mem_wdata = 32'd0;
			end
			S_WR: begin
				mem_we = 1'b1;
			end
			S_RD: begin
				mem_raddr = read_addr[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	cicd_mem #(.DEPTH(CELLS), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign in_stall = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= 5'd16;
			cells_y_q <= 5'd16;
			cells_z_q <= 5'd16;
			inv_x_q   <= 32'd65536;
			inv_y_q   <= 32'd65536;
			inv_z_q   <= 32'd65536;
			weight_q  <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CELLS_X: cells_x_q <= cfg_data[4:0];
				REG_CELLS_Y: cells_y_q <= cfg_data[4:0];
				REG_CELLS_Z: cells_z_q <= cfg_data[4:0];
				REG_INV_X:   inv_x_q   <= cfg_data;
				REG_INV_Y:   inv_y_q   <= cfg_data;
				REG_INV_Z:   inv_z_q   <= cfg_data;
				REG_WEIGHT:  weight_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q <= action;
				px_q  <= pos_x;
				py_q  <= pos_y;
				pz_q  <= pos_z;
				rx_q  <= read_x;
				ry_q  <= read_y;
				rz_q  <= read_z;
			end
			S_MUL: begin
				sx_q <= 48'((64'(px_q) * 64'(inv_x_q)) >> 16);
				sy_q <= 48'((64'(py_q) * 64'(inv_y_q)) >> 16);
				sz_q <= 48'((64'(pz_q) * 64'(inv_z_q)) >> 16);
			end
			S_CHK: begin
				x0_q <= ix[8:0];
				y0_q <= iy[8:0];
				z0_q <= iz[8:0];
				x1_q <= (ix[8:0] + 9'd1 == nx) ? 9'd0 : ix[8:0] + 9'd1;
				y1_q <= (iy[8:0] + 9'd1 == ny) ? 9'd0 : iy[8:0] + 9'd1;
				z1_q <= (iz[8:0] + 9'd1 == nz) ? 9'd0 : iz[8:0] + 9'd1;
				fx_q <= sx_q[15:0];
				fy_q <= sy_q[15:0];
				fz_q <= sz_q[15:0];
			end
			S_M1: p1_q <= p1_full[32:16];
			S_M2: p2_q <= p2_full[32:16];
			S_M3: begin
				w_q    <= w_full[48:16];
				addr_q <= corner_addr[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_ptr_q   <= '0;
			resp_q      <= 1'b0;
			corner_q    <= '0;
			res_dens_q  <= '0;
			res_oor_q   <= 1'b0;
			res_sat_q   <= 1'b0;
			out_valid_q <= 1'b0;
			dens_q      <= '0;
			oor_q       <= 1'b0;
			sat_q       <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					if (clr_ptr_q == (AW+1)'(CELLS - 1)) begin
						clr_ptr_q <= '0;
						state_q   <= resp_q ? S_DONE : S_IDLE;
					end else begin
						clr_ptr_q <= clr_ptr_q + 1'b1;
					end
				end
				S_IDLE: begin
					res_dens_q <= '0;
					res_oor_q  <= 1'b0;
					res_sat_q  <= 1'b0;
					corner_q   <= '0;
					if (in_valid) begin
						case (action)
							ACT_CLEAR: begin
								resp_q    <= 1'b1;
								clr_ptr_q <= '0;
								state_q   <= S_CLR;
							end
							ACT_DEPOSIT: state_q <= S_MUL;
							ACT_READ:    state_q <= S_RD;
							default:     state_q <= S_DONE;
						endcase
					end
				end
				S_MUL: state_q <= S_CHK;
				S_CHK: begin
					if (ix >= 32'(nx) || iy >= 32'(ny) || iz >= 32'(nz)) begin
						res_oor_q <= 1'b1;
						state_q   <= S_DONE;
					end else begin
						state_q <= S_M1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_WR;
				S_WR: begin
					if (sum_sat) begin
						res_sat_q <= 1'b1;
					end
					corner_q <= corner_q + 1'b1;
					state_q  <= (corner_q == 3'd7) ? S_DONE : S_M1;
				end
				S_RD: state_q <= S_DONE;
				S_DONE: begin
					if (act_q == ACT_READ && read_ok && !resp_q) begin
						res_dens_q <= mem_rdata;
						resp_q     <= 1'b1;
					end else if (out_load) begin
						dens_q      <= (act_q == ACT_READ && read_ok) ? res_dens_q : 32'd0;
						oor_q       <= res_oor_q;
						sat_q       <= res_sat_q;
						resp_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign density      = dens_q;
	assign out_of_range = oor_q;
	assign saturated    = sat_q;

endmodule

// ===== rtl/core/cicd_mem.sv =====
// Density grid memory with one write port and one registered read port.
module cicd_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the density deposit block: directed table and saturation items, then random transfers.
`timescale 1ns / 1ps
module tb_top
	import cicd_pkg::*;
();

	localparam int GX = 16;
	localparam int GY = 16;
	localparam int GZ = 16;
	localparam int NCELL = GX * GY * GZ;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [1:0]  act;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [3:0]  rx;
		logic [3:0]  ry;
		logic [3:0]  rz;
	} particle_t;

	typedef struct packed {
		logic [31:0] dens;
		logic        oor;
		logic        sat;
	} cell_result_t;

	typedef struct packed {
		particle_t    item;
		logic         known;
		cell_result_t res;
	} table_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] action;
	logic [31:0] pos_x, pos_y, pos_z;
	logic [3:0] read_x, read_y, read_z;
	logic out_valid;
	logic out_stall;
	logic [31:0] density;
	logic out_of_range;
	logic saturated;

	cloud_in_cell_density_deposit_top u_top (.*);

	logic [31:0] grid_model [NCELL];
	logic [4:0]  n_cells [3];
	logic [31:0] inv_scale [3];
	logic [31:0] weight_per_particle;
	cell_result_t expected_results [$];
	int errors;
	int rx_stall_mode;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#80_000_000;
		$display("[cloud_in_cell_density_deposit_top] ERROR");
		$finish;
	end

	function automatic int eff_count(logic [4:0] v, int g);
		if (v < 2) return 2;
		if (v > g) return g;
		return v;
	endfunction

	function automatic cell_result_t deposit_predict(particle_t p);
		cell_result_t r;
		logic [63:0] s [3];
		logic [31:0] pos [3];
		int n [3];
		int lo [3], hi [3];
		logic [63:0] wt [3][2];
		logic [63:0] w, sum;
		int a, b, c, addr;
		r = '0;
		pos[0] = p.px; pos[1] = p.py; pos[2] = p.pz;
		case (p.act)
			ACT_CLEAR: begin
				foreach (grid_model[i]) grid_model[i] = '0;
			end
			ACT_DEPOSIT: begin
				for (int k = 0; k < 3; k++) begin
					n[k] = eff_count(n_cells[k], 16);
					s[k] = (64'(pos[k]) * 64'(inv_scale[k])) >> 16;
				end
				if ((s[0] >> 16) >= n[0] || (s[1] >> 16) >= n[1] || (s[2] >> 16) >= n[2]) begin
					r.oor = 1'b1;
				end else begin
					for (int k = 0; k < 3; k++) begin
						lo[k] = int'(s[k] >> 16);
						hi[k] = (lo[k] + 1 == n[k]) ? 0 : lo[k] + 1;
						wt[k][1] = s[k] & 64'hFFFF;
						wt[k][0] = 64'h10000 - wt[k][1];
					end
					for (c = 0; c < 2; c++)
						for (b = 0; b < 2; b++)
							for (a = 0; a < 2; a++) begin
								w = (wt[0][a] * wt[1][b]) >> 16;
								w = (w * wt[2][c]) >> 16;
								w = (w * 64'(weight_per_particle)) >> 16;
								addr = ((a ? hi[0] : lo[0]) * GY + (b ? hi[1] : lo[1])) * GZ
									+ (c ? hi[2] : lo[2]);
								sum = 64'(grid_model[addr]) + w;
								if (sum > 64'hFFFF_FFFF) begin
									grid_model[addr] = 32'hFFFF_FFFF;
									r.sat = 1'b1;
								end else begin
									grid_model[addr] = sum[31:0];
								end
							end
				end
			end
			ACT_READ: r.dens = grid_model[(p.rx * GY + p.ry) * GZ + p.rz];
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CELLS_X: n_cells[0] = val[4:0];
			REG_CELLS_Y: n_cells[1] = val[4:0];
			REG_CELLS_Z: n_cells[2] = val[4:0];
			REG_INV_X:   inv_scale[0] = val;
			REG_INV_Y:   inv_scale[1] = val;
			REG_INV_Z:   inv_scale[2] = val;
			REG_WEIGHT:  weight_per_particle = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// One transfer; the predicted result is queued when the item is accepted.
	task automatic send_item(particle_t p, bit known, cell_result_t want);
		cell_result_t r;
		in_valid <= 1'b1;
		action <= p.act;
		pos_x <= p.px; pos_y <= p.py; pos_z <= p.pz;
		read_x <= p.rx; read_y <= p.ry; read_z <= p.rz;
		do @(posedge clk); while (in_stall);
		r = deposit_predict(p);
		if (known && r != want) report_mismatch("directed row", 32'(r), 32'(want));
		expected_results.push_back(r);
	endtask

	function automatic particle_t make_random();
		particle_t p;
		int n [3];
		logic [31:0] v [3];
		p.act = ($urandom_range(0, 99) < 70) ? ACT_DEPOSIT
			: ($urandom_range(0, 99) < 85 ? ACT_READ : ACT_NOP);
		if ($urandom_range(0, 199) == 0) p.act = ACT_CLEAR;
		for (int k = 0; k < 3; k++) begin
			n[k] = eff_count(n_cells[k], 16);
			if ($urandom_range(0, 9) == 0) v[k] = $urandom;
			else if (inv_scale[k] == 32'h10000) v[k] = $urandom_range(0, n[k] * 65536 - 1);
			else v[k] = $urandom;
		end
		p.px = v[0]; p.py = v[1]; p.pz = v[2];
		p.rx = 4'($urandom); p.ry = 4'($urandom); p.rz = 4'($urandom);
		return p;
	endfunction

	task automatic send_random(int count);
		particle_t p;
		for (int i = 0; i < count; i++) begin
			p = make_random();
			send_item(p, 1'b0, '0);
			if ($urandom_range(0, 5) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", density, 32'd0);
				end else begin
					cell_result_t e;
					e = expected_results.pop_front();
					if (density !== e.dens) report_mismatch("density", density, e.dens);
					if (out_of_range !== e.oor)
						report_mismatch("out_of_range", 32'(out_of_range), 32'(e.oor));
					if (saturated !== e.sat)
						report_mismatch("saturated", 32'(saturated), 32'(e.sat));
				end
			end
			case (rx_stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	table_row_t dir_rows [$];

	function automatic table_row_t row(logic [1:0] a, logic [31:0] x, logic [31:0] y,
		logic [31:0] z, logic [3:0] rx, logic [3:0] ry, logic [3:0] rz, logic known,
		logic [31:0] d, logic o, logic s);
		table_row_t t;
		t.item = '{a, x, y, z, rx, ry, rz};
		t.known = known;
		t.res = '{d, o, s};
		return t;
	endfunction

	initial begin
		errors = 0;
		rx_stall_mode = 0;
		cfg_we = 0; cfg_index = '0; cfg_data = '0;
		in_valid = 0; action = ACT_NOP;
		pos_x = 0; pos_y = 0; pos_z = 0; read_x = 0; read_y = 0; read_z = 0;
		out_stall = 0;
		foreach (grid_model[i]) grid_model[i] = '0;
		n_cells = '{5'd16, 5'd16, 5'd16};
		inv_scale = '{32'h10000, 32'h10000, 32'h10000};
		weight_per_particle = 32'h10000;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		dir_rows.push_back(row(ACT_READ, 0, 0, 0, 4'd0, 4'd0, 4'd0, 1, 0, 0, 0));
		dir_rows.push_back(row(ACT_READ, 0, 0, 0, 4'd15, 4'd15, 4'd15, 1, 0, 0, 0));
		dir_rows.push_back(row(ACT_DEPOSIT, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
		dir_rows.push_back(row(ACT_READ, 0, 0, 0, 4'd0, 4'd0, 4'd0, 1, 32'h10000, 0, 0));
		dir_rows.push_back(row(ACT_DEPOSIT, 32'h100000, 0, 0, 0, 0, 0, 1, 0, 1, 0));
		dir_rows.push_back(row(ACT_DEPOSIT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			0, 0, 0, 1, 0, 1, 0));
		dir_rows.push_back(row(ACT_DEPOSIT, 32'hF8000, 32'hF8000, 32'hF8000, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(ACT_READ, 0, 0, 0, 4'd0, 4'd0, 4'd0, 0, 0, 0, 0));
		dir_rows.push_back(row(ACT_READ, 0, 0, 0, 4'd15, 4'd15, 4'd15, 0, 0, 0, 0));
		dir_rows.push_back(row(ACT_DEPOSIT, 32'h18000, 32'h24000, 32'h3C000, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(ACT_NOP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			4'd15, 4'd15, 4'd15, 1, 0, 0, 0));
		dir_rows.push_back(row(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
		dir_rows.push_back(row(ACT_READ, 0, 0, 0, 4'd0, 4'd0, 4'd0, 1, 0, 0, 0));
		foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].res);
		in_valid <= 1'b0;
		wait_drained();

		// Heavy weight drives cells into saturation; cell counts below the minimum act as two.
		write_reg(REG_CELLS_X, 32'd0);
		write_reg(REG_CELLS_Y, 32'd1);
		write_reg(REG_CELLS_Z, 32'h1F);
		write_reg(REG_WEIGHT, 32'hFFFFFFFF);
		write_reg(REG_UNUSED, 32'h12345678);
		for (int i = 0; i < 6; i++) send_item('{ACT_DEPOSIT, 32'h8000, 32'h0, 32'h1, 0, 0, 0},
			1'b0, '0);
		send_item('{ACT_READ, 0, 0, 0, 4'd0, 4'd0, 4'd0}, 1'b0, '0);
		in_valid <= 1'b0;
		wait_drained();

		// A zero inverse cell size in x maps every x position to cell zero.
		write_reg(REG_INV_X, 32'd0);
		write_reg(REG_INV_Y, 32'hFFFFFFFF);
		write_reg(REG_INV_Z, 32'd1);
		write_reg(REG_WEIGHT, 32'd0);
		send_random(60);
		wait_drained();

		write_reg(REG_CELLS_X, 32'd5);
		write_reg(REG_CELLS_Y, 32'd2);
		write_reg(REG_CELLS_Z, 32'd16);
		write_reg(REG_INV_X, 32'h10000);
		write_reg(REG_INV_Y, 32'h10000);
		write_reg(REG_INV_Z, 32'h10000);
		write_reg(REG_WEIGHT, 32'h10000);
		rx_stall_mode = 1;
		send_random(250);
		wait_drained();

		write_reg(REG_CELLS_X, 32'd16);
		write_reg(REG_CELLS_Y, 32'd16);
		write_reg(REG_CELLS_Z, 32'd3);
		write_reg(REG_INV_Z, 32'h8000);
		write_reg(REG_WEIGHT, 32'h7FFFFFFF);
		rx_stall_mode = 2;
		send_random(220);
		wait_drained();

		write_reg(REG_CELLS_Z, 32'd16);
		write_reg(REG_INV_Z, 32'h10000);
		write_reg(REG_WEIGHT, $urandom);
		send_random(220);

		fork
			wait_drained();
			begin
				repeat (3_000_000) @(posedge clk);
				errors++;
			end
		join_any
		disable fork;
		if (errors == 0)
			$display("[cloud_in_cell_density_deposit_top] OK");
		else
			$display("[cloud_in_cell_density_deposit_top] ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/cicd_pkg.sv
rtl/core/cicd_mem.sv
rtl/core/cloud_in_cell_density_deposit_top.sv
tb/tb_top.sv
